### rtl/bpe_pkg.sv
// ============================================================================
// Bezier point evaluator package
// Shared widths, register indexes and rounding constants for the evaluator.
// ============================================================================
package bpe_pkg;

    // Coordinate format and curve parameter format.
    localparam int COORD_BITS  = 20;
    localparam int T_FRAC_BITS = 16;
    localparam int NUM_AXES    = 3;
    localparam int MAX_DEGREE  = 3;
    localparam int NUM_POINTS  = MAX_DEGREE + 1;

    // Derived widths.
    localparam int T_W        = T_FRAC_BITS + 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = DIFF_W + T_W + 1;
    localparam int PT_W       = NUM_AXES * COORD_BITS;
    localparam int CFG_DATA_W = PT_W;
    localparam int CFG_IDX_W  = 3;
    localparam int DEG_W      = 2;

    // Pipeline shape: one input stage, then a multiply and an add stage per level.
    localparam int NUM_STAGES = 2 * MAX_DEGREE + 1;
    localparam int T_STAGES   = 2 * MAX_DEGREE - 1;
    localparam int CNT_W      = $clog2(NUM_STAGES + 1);

    // Fixed-point constants.
    localparam logic [T_W-1:0]           T_ONE  = T_W'(1 << T_FRAC_BITS);
    localparam logic signed [PROD_W-1:0] T_HALF = PROD_W'(1 << (T_FRAC_BITS - 1));

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_POINT_0 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_POINT_1 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_POINT_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_POINT_3 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_DEGREE = CFG_IDX_W'(4);

    // Reset value of the degree register.
    localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(MAX_DEGREE);

endpackage

### rtl/bpe_lerp.sv
// ============================================================================
// Bezier point evaluator: linear interpolation lane
// One coordinate of one de Casteljau step, split into a multiply stage and a
// round-and-add stage. Computes a + ((b - a) * t + half) >>> T_FRAC_BITS,
// which equals (a * (one - t) + b * t + half) >>> T_FRAC_BITS exactly.
// ============================================================================
module bpe_lerp (
    input  logic                                clk,
    input  logic                                en_mul,
    input  logic                                en_add,
    input  logic signed [bpe_pkg::COORD_BITS-1:0] a,
    input  logic signed [bpe_pkg::COORD_BITS-1:0] b,
    input  logic        [bpe_pkg::T_W-1:0]        t,
    output logic signed [bpe_pkg::COORD_BITS-1:0] w
);
    import bpe_pkg::*;

    logic signed [DIFF_W-1:0]     diff;
    logic signed [T_W:0]          t_signed;
    logic signed [PROD_W-1:0]     prod_next;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [COORD_BITS-1:0] a_reg;
    logic signed [PROD_W-1:0]     biased;
    logic signed [PROD_W-1:0]     rounded;
    logic signed [PROD_W-1:0]     sum;
    logic signed [COORD_BITS-1:0] w_next;
    logic signed [COORD_BITS-1:0] w_reg;

    // Difference of the two points scaled by the parameter.
    always_comb
    begin
        diff      = DIFF_W'(b) - DIFF_W'(a);
        t_signed  = $signed({1'b0, t});
        prod_next = PROD_W'(diff) * PROD_W'(t_signed);
    end

    // Round, floor-shift and add back the start point. The result stays
    // between a and b, so the low bits hold it without overflow.
    always_comb
    begin
        biased  = prod_reg + T_HALF;
        rounded = biased >>> T_FRAC_BITS;
        sum     = rounded + PROD_W'(a_reg);
        w_next  = sum[COORD_BITS-1:0];
    end

    // Payload registers move only when their stage advances.
    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            prod_reg <= prod_next;
            a_reg    <= a;
        end
        if (en_add)
        begin
            w_reg <= w_next;
        end
    end

    assign w = w_reg;

endmodule

### rtl/bezier_point_evaluator.sv
// ============================================================================
// Bezier point evaluator
// Evaluates a Bezier curve of degree 0 to 3 at parameter t with de Casteljau's
// repeated linear interpolation, one interpolation level per pipeline pair.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_ready   t_param
//   result    out        out_valid / out_ready point_x, point_y, point_z
//   config    in         cfg_write             cfg_index, cfg_data
//
// One point per cycle sustained while out_ready stays high; seven register stages
// (one input stage plus a multiply and an add stage per level), and out_valid
// rises once the item has passed through them all to the last add stage.
// Levels above the programmed degree pass the first point through unchanged.
// Each stage advances when it is empty or the next stage advances, so bubbles
// are squeezed out while the result waits. Reset clears all valid bits and
// loads the degree register with 3 and the control points with zero.
// ============================================================================
module bezier_point_evaluator (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_write,
    input  logic        [bpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic        [bpe_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic        [bpe_pkg::T_W-1:0]          t_param,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [bpe_pkg::COORD_BITS-1:0]   point_x,
    output logic signed [bpe_pkg::COORD_BITS-1:0]   point_y,
    output logic signed [bpe_pkg::COORD_BITS-1:0]   point_z
);
    import bpe_pkg::*;

    logic [PT_W-1:0]        ctrl_point_reg [NUM_POINTS];
    logic [DEG_W-1:0]       degree_reg;
    logic [NUM_STAGES-1:0]  valid_reg;
    logic [NUM_STAGES-1:0]  valid_next;
    logic [NUM_STAGES-1:0]  stage_en;
    logic [T_W-1:0]         t_reg [T_STAGES];
    logic [T_W-1:0]         t_next;

    // Points of each level: level 0 is the control points.
    logic signed [COORD_BITS-1:0] lvl_pt [MAX_DEGREE+1][NUM_POINTS][NUM_AXES];
    logic [MAX_DEGREE:0]          level_on;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_POINTS; k++)
            begin
                ctrl_point_reg[k] <= '0;
            end
            degree_reg <= DEGREE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CTRL_POINT_0: ctrl_point_reg[0] <= cfg_data[PT_W-1:0];
                REG_CTRL_POINT_1: ctrl_point_reg[1] <= cfg_data[PT_W-1:0];
                REG_CTRL_POINT_2: ctrl_point_reg[2] <= cfg_data[PT_W-1:0];
                REG_CTRL_POINT_3: ctrl_point_reg[3] <= cfg_data[PT_W-1:0];
                REG_CURVE_DEGREE: degree_reg <= cfg_data[DEG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Stage enables ripple back from the output; a stage moves when it is
    // empty or its successor moves.
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int s = NUM_STAGES - 2; s >= 0; s--)
        begin
            stage_en[s] = !valid_reg[s] || stage_en[s+1];
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    // Valid bits travel with the data.
    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int s = 1; s < NUM_STAGES; s++)
        begin
            if (stage_en[s])
            begin
                valid_next[s] = valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Parameters above one saturate to one.
    always_comb
    begin
        t_next = (t_param > T_ONE) ? T_ONE : t_param;
    end

    // The parameter follows the items to each multiply stage.
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            t_reg[0] <= t_next;
        end
        for (int s = 1; s < T_STAGES; s++)
        begin
            if (stage_en[s])
            begin
                t_reg[s] <= t_reg[s-1];
            end
        end
    end

    // Unpack the control points into level zero.
    for (genvar i = 0; i < NUM_POINTS; i++)
    begin : g_unpack
        for (genvar c = 0; c < NUM_AXES; c++)
        begin : g_axis
            assign lvl_pt[0][i][c] = ctrl_point_reg[i][c*COORD_BITS +: COORD_BITS];
        end
    end

    // A level is active when the degree reaches it; an inactive level
    // interpolates a point with itself, which returns it unchanged.
    assign level_on[0] = 1'b1;
    for (genvar lv = 1; lv <= MAX_DEGREE; lv++)
    begin : g_level_on
        assign level_on[lv] = (degree_reg >= DEG_W'(lv));
    end

    // Interpolation lanes, one multiply and one add stage per level.
    for (genvar lv = 1; lv <= MAX_DEGREE; lv++)
    begin : g_level
        for (genvar i = 0; i < NUM_POINTS; i++)
        begin : g_lane
            for (genvar c = 0; c < NUM_AXES; c++)
            begin : g_axis
                if (i <= MAX_DEGREE - lv)
                begin : g_used
                    bpe_lerp u_lerp (
                        .clk    (clk),
                        .en_mul (stage_en[2*lv-1]),
                        .en_add (stage_en[2*lv]),
                        .a      (lvl_pt[lv-1][i][c]),
                        .b      (level_on[lv] ? lvl_pt[lv-1][i+1][c]
                                              : lvl_pt[lv-1][i][c]),
                        .t      (t_reg[2*lv-2]),
                        .w      (lvl_pt[lv][i][c])
                    );
                end
                else
                begin : g_unused
                    assign lvl_pt[lv][i][c] = '0;
                end
            end
        end
    end

    // The result is the first point of the last level.
    assign point_x = lvl_pt[MAX_DEGREE][0][0];
    assign point_y = lvl_pt[MAX_DEGREE][0][1];
    assign point_z = lvl_pt[MAX_DEGREE][0][2];

endmodule

### rtl/bpe_checker.sv
// ============================================================================
// Bezier point evaluator checker
// Port-level assertions on the result channel and on item bookkeeping.
// ============================================================================
module bpe_checker (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic                                    in_valid,
    input logic                                    in_ready,
    input logic                                    out_valid,
    input logic                                    out_ready,
    input logic signed [bpe_pkg::COORD_BITS-1:0]   point_x,
    input logic signed [bpe_pkg::COORD_BITS-1:0]   point_y,
    input logic signed [bpe_pkg::COORD_BITS-1:0]   point_z
);
    import bpe_pkg::*;

    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] inflight_reg;
    logic [CNT_W-1:0] inflight_next;

    assign in_xfer  = in_valid && in_ready;
    assign out_xfer = out_valid && out_ready;

    // Count items between input transfer and result transfer.
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (out_xfer && !in_xfer)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped during a stall");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(point_x) && $stable(point_y)
                                    && $stable(point_z))
        else $error("result changed during a stall");

    // No result appears without an item in flight.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result offered with no item in flight");

    // An empty pipeline always takes a new item.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg == '0 |-> in_ready)
        else $error("empty pipeline refused an input transfer");

    // Never more items in flight than pipeline stages.
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(NUM_STAGES))
        else $error("more items in flight than pipeline stages");

endmodule

bind bezier_point_evaluator bpe_checker u_bpe_checker (.*);
